FILE: sv/b64ud_pkg.sv
// Shared types and codes for the base64 upload session decoder.
// No dependencies; the core, the engine and both testbench files import this package.
package b64ud_pkg;

  // Largest upload length a begin request may announce
  localparam logic [15:0] MAX_LEN = 16'd32768;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_END   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_BIG   = 3'd1,
    ST_BUSY      = 3'd2,
    ST_NO_UPLOAD = 3'd3,
    ST_BAD_CHUNK = 3'd4,
    ST_TOO_MUCH  = 3'd5,
    ST_SHORT     = 3'd6
  } status_t;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;

  // One result as it leaves the decode step
  typedef struct packed {
    status_t     status;
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic [14:0] byte_index;
    logic        chunk_done;
    logic [15:0] received_count;
    logic [15:0] script_length;
  } result_t;

endpackage

FILE: sv/b64ud_in_if.sv
// Request channel of the upload decoder: valid/ready plus one input item.
// Stand-alone; widths follow the item fields.
interface b64ud_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] upload_length;
  logic [7:0]  char_code;
  logic        loader_busy;

  modport source (output valid, kind, upload_length, char_code, loader_busy, input ready);
  modport sink   (input valid, kind, upload_length, char_code, loader_busy, output ready);
endinterface

FILE: sv/b64ud_out_if.sv
// Result channel of the upload decoder: valid/ready plus one result item.
// Stand-alone; widths follow the result fields.
interface b64ud_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        byte_valid;
  logic [7:0]  data_byte;
  logic [14:0] byte_index;
  logic        chunk_done;
  logic [15:0] received_count;
  logic [15:0] script_length;

  modport source (output valid, status, byte_valid, data_byte, byte_index, chunk_done,
                  received_count, script_length, input ready);
  modport sink   (input valid, status, byte_valid, data_byte, byte_index, chunk_done,
                  received_count, script_length, output ready);
endinterface

FILE: sv/base64_upload_session_decoder_core.sv
// Base64 upload session decoder: takes one request per cycle and returns exactly
// one result for each, as long as the result register is free or being emptied;
// each result is registered in the cycle after acceptance. The decode step
// (character map, six-bit shift into the accumulator, length compare) sits between
// the request port and the result register, and the block keeps accepting while a
// result waits as long as the consumer takes it in the same cycle.
module base64_upload_session_decoder_core import b64ud_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  b64ud_in_if.sink      item,
  b64ud_out_if.source   result
);

  result_t res_comb;
  result_t res_q;
  logic    res_valid;
  logic    accept;

  // Take a request when the result register is free or being emptied
  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;

  b64ud_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .advance       (accept),
    .kind          (item.kind),
    .upload_length (item.upload_length),
    .char_code     (item.char_code),
    .loader_busy   (item.loader_busy),
    .res           (res_comb)
  );

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_comb;
    end
  end

  assign result.valid          = res_valid;
  assign result.status         = res_q.status;
  assign result.byte_valid     = res_q.byte_valid;
  assign result.data_byte      = res_q.data_byte;
  assign result.byte_index     = res_q.byte_index;
  assign result.chunk_done     = res_q.chunk_done;
  assign result.received_count = res_q.received_count;
  assign result.script_length  = res_q.script_length;

  // Every accepted request shows a result on the next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> res_valid)
    else $error("accepted request produced no result");
  // A decoded byte always comes with an ok status
  assert property (@(posedge clk) disable iff (rst)
      res_valid && res_q.byte_valid |-> res_q.status == ST_OK)
    else $error("byte emitted with error status");
  // A byte and a chunk close never share one result
  assert property (@(posedge clk) disable iff (rst)
      res_valid |-> !(res_q.byte_valid && res_q.chunk_done))
    else $error("byte and chunk close in one result");

endmodule

FILE: sv/b64ud_engine.sv
// Session state and combinational decode step of the upload decoder.
// Depends on b64ud_pkg; the top level registers the result it produces.
module b64ud_engine import b64ud_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [1:0]    kind,
  input  logic [15:0]   upload_length,
  input  logic [7:0]    char_code,
  input  logic          loader_busy,
  output result_t       res
);

  logic        uploading, uploading_next;
  logic [15:0] expected_count, expected_count_next;
  logic [15:0] got_count, got_count_next;
  logic [15:0] complete_length, complete_length_next;
  logic [15:0] bit_accumulator, bit_accumulator_next;
  logic [3:0]  pending_bits, pending_bits_next;
  logic        in_chunk, in_chunk_next;
  logic        skipping_rest, skipping_rest_next;

  // Map a character to its six-bit value; valid low for a non-alphabet code
  function automatic logic [6:0] sextet(input logic [7:0] ch);
    logic [6:0] r;
    r = 7'd0;
    if (ch >= "A" && ch <= "Z")      r = {1'b1, 6'(ch - 8'h41)};
    else if (ch >= "a" && ch <= "z") r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
    else if (ch >= "0" && ch <= "9") r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
    else if (ch == "+")              r = {1'b1, 6'd62};
    else if (ch == "/")              r = {1'b1, 6'd63};
    return r;
  endfunction

  logic [6:0]  sx;
  logic [15:0] acc_base;
  logic [3:0]  pend_base;
  logic [3:0]  pend_sum;
  logic [3:0]  pend_left;
  logic        skip_eff;

  assign sx        = sextet(char_code);
  assign acc_base  = in_chunk ? bit_accumulator : 16'd0;
  assign pend_base = in_chunk ? pending_bits : 4'd0;
  assign skip_eff  = in_chunk & skipping_rest;
  assign pend_sum  = pend_base + 4'd6;
  assign pend_left = pend_sum - 4'd8;

  // Work out the next session state and the result of this request
  always_comb begin
    uploading_next       = uploading;
    expected_count_next  = expected_count;
    got_count_next       = got_count;
    complete_length_next = complete_length;
    bit_accumulator_next = bit_accumulator;
    pending_bits_next    = pending_bits;
    in_chunk_next        = in_chunk;
    skipping_rest_next   = skipping_rest;
    res                  = '0;
    res.status           = ST_OK;

    unique case (kind_t'(kind))
      KIND_BEGIN: begin
        in_chunk_next      = 1'b0;
        skipping_rest_next = 1'b0;
        if (upload_length == 16'd0 || upload_length > MAX_LEN) begin
          res.status = ST_TOO_BIG;
        end else if (loader_busy) begin
          res.status = ST_BUSY;
        end else begin
          complete_length_next = 16'd0;
          expected_count_next  = upload_length;
          got_count_next       = 16'd0;
          uploading_next       = 1'b1;
        end
      end
      KIND_END: begin
        in_chunk_next      = 1'b0;
        skipping_rest_next = 1'b0;
        if (!uploading) begin
          res.status = ST_NO_UPLOAD;
        end else begin
          uploading_next = 1'b0;
          if (got_count != expected_count) res.status = ST_SHORT;
          else complete_length_next = got_count;
        end
      end
      KIND_CHAR: begin
        // Start of a chunk clears the accumulator
        if (!in_chunk) begin
          in_chunk_next        = 1'b1;
          skipping_rest_next   = 1'b0;
          bit_accumulator_next = 16'd0;
          pending_bits_next    = 4'd0;
        end
        if (!in_chunk && !uploading) begin
          res.status         = ST_NO_UPLOAD;
          in_chunk_next      = (char_code != CHAR_NUL);
          skipping_rest_next = (char_code != CHAR_NUL);
        end else if (char_code == CHAR_NUL) begin
          res.chunk_done     = uploading;
          res.received_count = uploading ? got_count : 16'd0;
          in_chunk_next      = 1'b0;
          skipping_rest_next = 1'b0;
        end else if (skip_eff) begin
          // swallow the rest of the chunk
        end else if (char_code == CHAR_EQUALS) begin
          skipping_rest_next = 1'b1;
        end else if (!sx[6]) begin
          uploading_next     = 1'b0;
          skipping_rest_next = 1'b1;
          res.status         = ST_BAD_CHUNK;
        end else begin
          bit_accumulator_next = {acc_base[9:0], sx[5:0]};
          if (pend_sum >= 4'd8) begin
            pending_bits_next = pend_left;
            if (got_count >= expected_count) begin
              uploading_next     = 1'b0;
              skipping_rest_next = 1'b1;
              res.status         = ST_TOO_MUCH;
            end else begin
              res.byte_valid = 1'b1;
              res.data_byte  = 8'(bit_accumulator_next >> pend_left);
              res.byte_index = got_count[14:0];
              got_count_next = got_count + 16'd1;
            end
          end else begin
            pending_bits_next = pend_sum;
          end
        end
      end
      default: begin
        // unused kind: no effect
      end
    endcase

    res.script_length = complete_length_next;
  end

  // Commit the state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      uploading       <= 1'b0;
      expected_count  <= 16'd0;
      got_count       <= 16'd0;
      complete_length <= 16'd0;
      bit_accumulator <= 16'd0;
      pending_bits    <= 4'd0;
      in_chunk        <= 1'b0;
      skipping_rest   <= 1'b0;
    end else if (advance) begin
      uploading       <= uploading_next;
      expected_count  <= expected_count_next;
      got_count       <= got_count_next;
      complete_length <= complete_length_next;
      bit_accumulator <= bit_accumulator_next;
      pending_bits    <= pending_bits_next;
      in_chunk        <= in_chunk_next;
      skipping_rest   <= skipping_rest_next;
    end
  end

  // Pending bits never reach a full byte between requests
  assert property (@(posedge clk) disable iff (rst) pending_bits < 4'd8)
    else $error("pending bit count out of range");
  // Bytes never run past the announced length while uploading
  assert property (@(posedge clk) disable iff (rst) uploading |-> got_count <= expected_count)
    else $error("byte count beyond announced length");
  // Skipping only happens inside a chunk
  assert property (@(posedge clk) disable iff (rst) skipping_rest |-> in_chunk)
    else $error("skip flag outside a chunk");

endmodule

FILE: tb/b64ud_decode_checker.sv
`timescale 1ns / 100ps
// Result checker for the base64 upload session decoder: watches both channels,
// predicts one result per accepted request and compares it with the block.
// Depends on b64ud_pkg and the b64ud_in_if / b64ud_out_if channel interfaces.
module b64ud_decode_checker import b64ud_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  b64ud_in_if   req_ch,
  b64ud_out_if  res_ch,
  output int    mismatch_n,
  output int    outstanding
);

  // Predicted session state
  logic        uploading;
  logic        in_chunk;
  logic        skipping_rest;
  logic [15:0] expected_len;
  logic [15:0] got_len;
  logic [15:0] script_len;
  logic [15:0] acc;
  int          pend_bits;

  result_t     expected_results[$];

  // Map a base64 symbol to its six-bit value; return 0 for anything else
  function automatic bit sextet_value(input logic [7:0] c, output logic [5:0] v);
    v = 6'd0;
    if (c >= "A" && c <= "Z") begin
      v = 6'(c - "A");
      return 1'b1;
    end
    if (c >= "a" && c <= "z") begin
      v = 6'(c - "a" + 8'd26);
      return 1'b1;
    end
    if (c >= "0" && c <= "9") begin
      v = 6'(c - "0" + 8'd52);
      return 1'b1;
    end
    if (c == "+") begin
      v = 6'd62;
      return 1'b1;
    end
    if (c == "/") begin
      v = 6'd63;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the session state by one request and build the result it causes
  function automatic result_t decode_request(input kind_t kind, input logic [15:0] len,
                                             input logic [7:0] ch, input logic busy);
    result_t     r;
    logic [5:0]  six;
    logic [15:0] shifted;
    logic        refused;
    r = '0;
    r.status = ST_OK;
    refused = 1'b0;

    // Begin and end close any chunk in progress
    if (kind == KIND_BEGIN || kind == KIND_END) begin
      in_chunk = 1'b0;
      skipping_rest = 1'b0;
    end

    case (kind)
      KIND_BEGIN: begin
        if (len == 16'd0 || len > MAX_LEN) begin
          r.status = ST_TOO_BIG;
        end else if (busy) begin
          r.status = ST_BUSY;
        end else begin
          script_len = 16'd0;
          expected_len = len;
          got_len = 16'd0;
          uploading = 1'b1;
        end
      end
      KIND_END: begin
        if (!uploading) begin
          r.status = ST_NO_UPLOAD;
        end else begin
          uploading = 1'b0;
          if (got_len != expected_len) r.status = ST_SHORT;
          else script_len = got_len;
        end
      end
      KIND_CHAR: begin
        // Open a chunk: clear the accumulator, refuse it without an upload
        if (!in_chunk) begin
          in_chunk = 1'b1;
          skipping_rest = 1'b0;
          acc = 16'd0;
          pend_bits = 0;
          if (!uploading) begin
            r.status = ST_NO_UPLOAD;
            in_chunk = (ch != CHAR_NUL);
            skipping_rest = (ch != CHAR_NUL);
            refused = 1'b1;
          end
        end
        if (!refused) begin
          if (ch == CHAR_NUL) begin
            r.chunk_done = uploading;
            r.received_count = uploading ? got_len : 16'd0;
            in_chunk = 1'b0;
            skipping_rest = 1'b0;
          end else if (!skipping_rest) begin
            if (ch == CHAR_EQUALS) begin
              skipping_rest = 1'b1;
            end else if (!sextet_value(ch, six)) begin
              uploading = 1'b0;
              skipping_rest = 1'b1;
              r.status = ST_BAD_CHUNK;
            end else begin
              acc = {acc[9:0], six};
              pend_bits += 6;
              // Emit a byte once eight bits are pending, unless the length is used up
              if (pend_bits >= 8) begin
                pend_bits -= 8;
                if (got_len >= expected_len) begin
                  uploading = 1'b0;
                  skipping_rest = 1'b1;
                  r.status = ST_TOO_MUCH;
                end else begin
                  shifted = acc >> pend_bits;
                  r.byte_valid = 1'b1;
                  r.data_byte = shifted[7:0];
                  r.byte_index = got_len[14:0];
                  got_len = got_len + 16'd1;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase

    r.script_length = script_len;
    return r;
  endfunction

  // Count a failure, print the first ten in full
  task automatic note_mismatch(input bit had_expected, input result_t want, input result_t seen);
    mismatch_n++;
    if (mismatch_n <= 10) begin
      if (had_expected)
        $display("%0t: result mismatch", $time);
      else
        $display("%0t: result with no request waiting", $time);
      if (had_expected)
        $display("  expected status=%0d byte=%0b/%02h@%0d chunk=%0b/%0d script=%0d",
                 want.status, want.byte_valid, want.data_byte, want.byte_index,
                 want.chunk_done, want.received_count, want.script_length);
      $display("  actual   status=%0d byte=%0b/%02h@%0d chunk=%0b/%0d script=%0d",
               seen.status, seen.byte_valid, seen.data_byte, seen.byte_index,
               seen.chunk_done, seen.received_count, seen.script_length);
    end
  endtask

  // Check results first, then queue the prediction for a request taken this edge
  always @(posedge clk) begin : watch_channels
    result_t seen;
    result_t want;
    if (rst) begin
      uploading = 1'b0;
      in_chunk = 1'b0;
      skipping_rest = 1'b0;
      expected_len = 16'd0;
      got_len = 16'd0;
      script_len = 16'd0;
      acc = 16'd0;
      pend_bits = 0;
      expected_results.delete();
      mismatch_n = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        seen.status = status_t'(res_ch.status);
        seen.byte_valid = res_ch.byte_valid;
        seen.data_byte = res_ch.data_byte;
        seen.byte_index = res_ch.byte_index;
        seen.chunk_done = res_ch.chunk_done;
        seen.received_count = res_ch.received_count;
        seen.script_length = res_ch.script_length;
        if (expected_results.size() == 0) begin
          note_mismatch(1'b0, '0, seen);
        end else begin
          want = expected_results.pop_front();
          if (seen.status !== want.status || seen.byte_valid !== want.byte_valid ||
              seen.data_byte !== want.data_byte || seen.byte_index !== want.byte_index ||
              seen.chunk_done !== want.chunk_done ||
              seen.received_count !== want.received_count ||
              seen.script_length !== want.script_length)
            note_mismatch(1'b1, want, seen);
        end
      end
      if (req_ch.valid && req_ch.ready)
        expected_results.push_back(decode_request(kind_t'(req_ch.kind), req_ch.upload_length,
                                                  req_ch.char_code, req_ch.loader_busy));
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: tb/base64_upload_session_decoder_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for base64_upload_session_decoder_core: clock, reset, request
// stimulus, result back-pressure, watchdog and the final verdict.
// Depends on b64ud_pkg, both channel interfaces and b64ud_decode_checker.
module base64_upload_session_decoder_core_tb;
  import b64ud_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RANDOM_ITEMS    = 700;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatch_n;
  int   outstanding;
  int   quiet_n;
  int   sent_n;
  bit   tx_idle_on;
  bit   rx_idle_on;
  bit   hold_off_req;
  bit   rx_holding;

  b64ud_in_if  req_ch();
  b64ud_out_if res_ch();

  base64_upload_session_decoder_core dut (
    .clk(clk),
    .rst(rst),
    .item(req_ch),
    .result(res_ch)
  );

  b64ud_decode_checker decode_check (
    .clk(clk),
    .rst(rst),
    .req_ch(req_ch),
    .res_ch(res_ch),
    .mismatch_n(mismatch_n),
    .outstanding(outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    if (v < 6'd26) return "A" + v;
    if (v < 6'd52) return "a" + v - 8'd26;
    if (v < 6'd62) return "0" + v - 8'd52;
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_request(input kind_t kind, input logic [15:0] len,
                              input logic [7:0] ch, input logic busy);
    int gap;
    gap = tx_idle_on ? idle_cycles() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.upload_length <= len;
    req_ch.char_code <= ch;
    req_ch.loader_busy <= busy;
    do @(posedge clk); while (!req_ch.ready);
    sent_n++;
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_request(KIND_CHAR, 16'($urandom_range(0, 16'hFFFF)), ch, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_begin(input logic [15:0] len, input logic busy);
    send_request(KIND_BEGIN, len, 8'($urandom_range(0, 255)), busy);
  endtask

  task automatic send_end();
    send_request(KIND_END, 16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise();
    send_request(kind_t'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One upload: begin, base64 text split into chunks, end; some of them broken
  task automatic run_upload_session();
    logic [15:0] len;
    logic [23:0] triple;
    logic [7:0]  text[$];
    int          n_bytes;
    int          flavor;
    int          left;
    flavor = $urandom_range(0, 99);
    len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                      : 16'($urandom_range(1, 24));
    n_bytes = (len > 16'd30) ? int'($urandom_range(0, 30)) : int'(len);
    if (flavor < 12) n_bytes += int'($urandom_range(1, 3));
    else if (flavor < 22 && n_bytes > 0) n_bytes -= 1;

    // Encode random bytes, padding the last group
    for (int i = 0; i < n_bytes; i += 3) begin
      left = n_bytes - i;
      triple = 24'($urandom);
      if (left == 1) triple[15:0] = 16'd0;
      if (left == 2) triple[7:0] = 8'd0;
      text.push_back(b64_symbol(triple[23:18]));
      text.push_back(b64_symbol(triple[17:12]));
      text.push_back(left > 1 ? b64_symbol(triple[11:6]) : CHAR_EQUALS);
      text.push_back(left > 2 ? b64_symbol(triple[5:0]) : CHAR_EQUALS);
    end
    if (flavor >= 22 && flavor < 30)
      text.insert($urandom_range(0, text.size()), 8'($urandom_range(1, 255)));

    send_begin(len, $urandom_range(0, 19) == 0);
    for (int k = 0; k < text.size(); k++) begin
      if ($urandom_range(0, 39) == 0) send_noise();
      send_char(text[k]);
      // Close chunks mostly on group boundaries
      if (k + 1 < text.size() &&
          ((k % 4 == 3 && $urandom_range(0, 3) == 0) || $urandom_range(0, 40) == 0))
        send_char(CHAR_NUL);
    end
    if (flavor < 30 || flavor >= 34) send_char(CHAR_NUL);
    if (flavor < 34 || flavor >= 37) send_end();
  endtask

  // Result side: random stalls, and one long hold-off on request
  initial begin : result_sink
    int gap;
    res_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req && !rx_holding) begin
        rx_holding = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end else if (rx_idle_on) begin
        gap = idle_cycles();
        if (gap > 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_n <= 0;
    end else begin
      quiet_n <= quiet_n + 1;
      if (quiet_n >= QUIET_LIMIT) begin
        $display("base64_upload_session_decoder_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int session_n;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_NONE;
    req_ch.upload_length = 16'd0;
    req_ch.char_code = CHAR_NUL;
    req_ch.loader_busy = 1'b0;
    sent_n = 0;
    session_n = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // No upload open: chunk refused and swallowed, end refused, lone NUL refused
    send_char("A");
    send_char(8'hFF);
    send_end();
    send_char(CHAR_NUL);
    // Reject empty and oversized lengths and a busy loader
    send_begin(16'd0, 1'b0);
    send_begin(MAX_LEN + 16'd1, 1'b0);
    send_begin(MAX_LEN, 1'b1);
    // Four bytes in two chunks; text after the padding is not checked
    send_begin(16'd4, 1'b0);
    send_char("T");
    send_char("W");
    send_char("F");
    send_char("u");
    send_char(CHAR_NUL);
    send_char("Q");
    send_char("Q");
    send_char(CHAR_EQUALS);
    send_char("*");
    send_char(CHAR_NUL);
    send_end();
    send_request(KIND_NONE, 16'hFFFF, 8'hFF, 1'b1);
    // One byte announced, a second one completed
    send_begin(16'd1, 1'b0);
    send_char("/");
    send_char("+");
    send_char("/");
    // Begin and end arriving mid-chunk, largest length
    send_begin(MAX_LEN, 1'b0);
    send_char("A");
    send_char("B");
    send_end();
    // Bad character, then the closing NUL of the swallowed chunk
    send_begin(16'd1, 1'b0);
    send_char("~");
    send_char(CHAR_NUL);
    drain_results();

    // Random sessions with changing idle patterns
    while (sent_n < RANDOM_ITEMS + 30) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (session_n == 4) begin
        // Hold results back while requests keep coming
        tx_idle_on = 1'b0;
        req_ch.valid <= 1'b0;
        hold_off_req = 1'b1;
        do @(posedge clk); while (!rx_holding);
        hold_off_req = 1'b0;
      end
      run_upload_session();
      if (session_n % 8 == 7) drain_results();
      session_n++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (outstanding != 0)
      $display("%0d expected results never arrived", outstanding);
    if (mismatch_n == 0 && outstanding == 0)
      $display("base64_upload_session_decoder_core_tb OK");
    else
      $display("base64_upload_session_decoder_core_tb NOT OK");
    $finish;
  end

endmodule
